// ----- src/x86d_pkg.sv -----
// ----------------------------------------------------------------------------
// x86d_pkg
// Shared codes and opcode classification helpers for the 16-bit instruction
// decoder: form and operation codes, ModRM displacement and data lengths.
// ----------------------------------------------------------------------------
`default_nettype none

package x86d_pkg;

  // instruction forms as reported on the result word
  typedef enum logic [2:0] {
    F_RMREG   = 3'd0,
    F_IMMRM   = 3'd1,
    F_IMMREG  = 3'd2,
    F_ACCADDR = 3'd3,
    F_SEG     = 3'd4,
    F_IMMACC  = 3'd5,
    F_JUMP    = 3'd6
  } form_t;

  // operation kinds
  localparam logic [2:0] OP_MOV  = 3'd0;
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_CMP  = 3'd3;
  localparam logic [2:0] OP_JUMP = 3'd4;

  // arithmetic selector values (opcode bits 5:3 or ModRM reg)
  localparam logic [2:0] SEL_ADD = 3'd0;
  localparam logic [2:0] SEL_SUB = 3'd5;
  localparam logic [2:0] SEL_CMP = 3'd7;

  // opcodes needing special treatment
  localparam logic [7:0] OPC_MOV_IMM_B  = 8'hC6;
  localparam logic [7:0] OPC_MOV_IMM_W  = 8'hC7;
  localparam logic [7:0] OPC_SEG_TO_RM  = 8'h8C;
  localparam logic [7:0] OPC_SEG_FROM_RM = 8'h8E;
  localparam logic [7:0] OPC_GRP_SX     = 8'h83;

  localparam logic [2:0] RM_DIRECT = 3'b110;
  localparam logic [15:0] SIGN_FILL = 16'hFF00;

  // true when the first byte is part of the supported subset
  function automatic logic classify_ok(input logic [7:0] fb);
    logic [5:0] h6;
    logic [6:0] h7;
    h6 = fb[7:2];
    h7 = fb[7:1];
    return (h6 == 6'h22) || (h7 == 7'h63) || (fb[7:4] == 4'hB) ||
           (h7 == 7'h50) || (h7 == 7'h51) ||
           (fb == OPC_SEG_TO_RM) || (fb == OPC_SEG_FROM_RM) ||
           (h6 == 6'h20) || (h6 == 6'h00) || (h6 == 6'h0A) || (h6 == 6'h0E) ||
           (h7 == 7'h02) || (h7 == 7'h16) || (h7 == 7'h1E) ||
           (fb[7:4] == 4'h7) || (fb[7:2] == 6'h38);
  endfunction

  // form of a first byte, register/memory form when unknown
  function automatic form_t classify_form(input logic [7:0] fb);
    logic [5:0] h6;
    logic [6:0] h7;
    form_t f;
    h6 = fb[7:2];
    h7 = fb[7:1];
    f = F_RMREG;
    if (h6 == 6'h22) f = F_RMREG;
    else if (h7 == 7'h63) f = F_IMMRM;
    else if (fb[7:4] == 4'hB) f = F_IMMREG;
    else if ((h7 == 7'h50) || (h7 == 7'h51)) f = F_ACCADDR;
    else if ((fb == OPC_SEG_TO_RM) || (fb == OPC_SEG_FROM_RM)) f = F_SEG;
    else if (h6 == 6'h20) f = F_IMMRM;
    else if ((h6 == 6'h00) || (h6 == 6'h0A) || (h6 == 6'h0E)) f = F_RMREG;
    else if ((h7 == 7'h02) || (h7 == 7'h16) || (h7 == 7'h1E)) f = F_IMMACC;
    else if ((fb[7:4] == 4'h7) || (fb[7:2] == 6'h38)) f = F_JUMP;
    return f;
  endfunction

  function automatic logic has_modrm(input form_t f);
    return (f == F_RMREG) || (f == F_IMMRM) || (f == F_SEG);
  endfunction

  // displacement bytes implied by a ModRM byte
  function automatic logic [1:0] disp_len(input logic [7:0] modrm);
    logic [1:0] n;
    case (modrm[7:6])
      2'd0:    n = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
      2'd1:    n = 2'd1;
      2'd2:    n = 2'd2;
      default: n = 2'd0;
    endcase
    return n;
  endfunction

  // immediate or offset bytes following the displacement
  function automatic logic [1:0] data_len(input logic [7:0] fb);
    logic [1:0] n;
    case (classify_form(fb))
      F_IMMRM: begin
        if ((fb == OPC_MOV_IMM_B) || (fb == OPC_MOV_IMM_W)) n = fb[0] ? 2'd2 : 2'd1;
        else n = (fb[1:0] == 2'b01) ? 2'd2 : 2'd1;
      end
      F_IMMREG:  n = fb[3] ? 2'd2 : 2'd1;
      F_ACCADDR: n = 2'd2;
      F_IMMACC:  n = fb[0] ? 2'd2 : 2'd1;
      F_JUMP:    n = 2'd1;
      default:   n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- src/x86_16bit_instruction_decoder.sv -----
// ----------------------------------------------------------------------------
// x86_16bit_instruction_decoder
// Byte-serial decoder for a subset of the 8086 instruction set: mov, add,
// sub, cmp and the conditional jumps and loops.
// ----------------------------------------------------------------------------
// Usage: code bytes enter on the code channel (code_valid, code_stall,
// code_byte), one byte per word. The block holds the partial instruction and
// sends one result word on the result channel (result_valid, result_stall and
// the decoded fields) when the last byte of an instruction has arrived, or at
// once for an unknown first byte (bad_opcode set, length 1).
// Each byte lands in an input register, is decoded against the held state in
// one pass and, when it completes an instruction, writes the result register.
// Throughput: one byte per cycle unless the receiver stalls, set by the
// single decode pass between the input and result registers.
// Reset: rst (synchronous, active high) empties both registers and returns
// the decoder to the idle state awaiting a first byte.
// Stall: while the result register holds a word the receiver stalls, the
// byte in the input register waits and code_stall rises; the result word
// holds until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module x86_16bit_instruction_decoder
  import x86d_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // code channel
  input  wire logic               code_valid,
  output logic                    code_stall,
  input  wire logic [7:0]         code_byte,
  // result channel
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic [2:0]              op_kind,
  output logic [2:0]              form,
  output logic [7:0]              opcode_byte,
  output logic                    word_flag,
  output logic                    direction_flag,
  output logic [1:0]              mode_field,
  output logic [2:0]              reg_field,
  output logic [2:0]              rm_field,
  output logic signed [15:0]      displacement,
  output logic [15:0]             data_value,
  output logic [2:0]              length,
  output logic                    bad_opcode
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_MODRM   = 3'd1,
    PH_DISP_LO = 3'd2,
    PH_DISP_HI = 3'd3,
    PH_DATA_LO = 3'd4,
    PH_DATA_HI = 3'd5
  } phase_t;

  // input register
  logic       in_full;
  logic [7:0] in_byte;

  // held instruction state
  phase_t      phase;
  logic [7:0]  held_first_byte;
  logic [7:0]  held_modrm;
  logic [15:0] disp_accum;
  logic [15:0] data_accum;
  logic [2:0]  bytes_taken;

  logic advance;

  // decode pass results
  phase_t      phase_next;
  logic [7:0]  fb_next;
  logic [7:0]  modrm_next;
  logic [15:0] disp_next;
  logic [15:0] data_next;
  logic [2:0]  bytes_next;
  logic        emit;
  logic        first_bad;

  // result fields
  form_t       res_form;
  logic [2:0]  res_op;
  logic        res_w;
  logic        res_d;
  logic [1:0]  res_mod;
  logic [2:0]  res_reg;
  logic [2:0]  res_rm;
  logic        res_ok;

  // handshake: the input byte moves on when the result register can take a word
  assign advance    = in_full && (!result_valid || !result_stall);
  assign code_stall = in_full && !advance;

  // state update for the byte in the input register
  always_comb begin
    phase_next = phase;
    fb_next    = held_first_byte;
    modrm_next = held_modrm;
    disp_next  = disp_accum;
    data_next  = data_accum;
    bytes_next = bytes_taken + 3'd1;
    emit       = 1'b0;
    first_bad  = 1'b0;
    case (phase)
      PH_MODRM: begin
        modrm_next = in_byte;
        if (disp_len(in_byte) != 2'd0) phase_next = PH_DISP_LO;
        else if (data_len(held_first_byte) != 2'd0) phase_next = PH_DATA_LO;
        else emit = 1'b1;
      end
      PH_DISP_LO: begin
        disp_next = {8'h00, in_byte};
        if (disp_len(held_modrm) == 2'd2) begin
          phase_next = PH_DISP_HI;
        end else begin
          if (in_byte[7]) disp_next = disp_next | SIGN_FILL;
          if (data_len(held_first_byte) != 2'd0) phase_next = PH_DATA_LO;
          else emit = 1'b1;
        end
      end
      PH_DISP_HI: begin
        disp_next = disp_accum | {in_byte, 8'h00};
        if (data_len(held_first_byte) != 2'd0) phase_next = PH_DATA_LO;
        else emit = 1'b1;
      end
      PH_DATA_LO: begin
        data_next = {8'h00, in_byte};
        if (data_len(held_first_byte) == 2'd2) begin
          phase_next = PH_DATA_HI;
        end else begin
          if ((held_first_byte == OPC_GRP_SX) && in_byte[7]) data_next = data_next | SIGN_FILL;
          emit = 1'b1;
        end
      end
      PH_DATA_HI: begin
        data_next = data_accum | {in_byte, 8'h00};
        emit      = 1'b1;
      end
      default: begin
        // first byte of a new instruction
        fb_next    = in_byte;
        modrm_next = 8'h00;
        disp_next  = 16'h0000;
        data_next  = 16'h0000;
        bytes_next = 3'd1;
        if (!classify_ok(in_byte)) begin
          first_bad  = 1'b1;
          emit       = 1'b1;
          phase_next = PH_IDLE;
        end else if (has_modrm(classify_form(in_byte))) begin
          phase_next = PH_MODRM;
        end else begin
          phase_next = PH_DATA_LO;
        end
      end
    endcase
    if (emit) phase_next = PH_IDLE;
  end

  // field decode of a completed instruction
  always_comb begin
    res_form = classify_form(fb_next);
    res_op   = OP_MOV;
    res_w    = 1'b0;
    res_d    = 1'b0;
    res_reg  = 3'd0;
    res_ok   = 1'b1;
    case (res_form)
      F_RMREG: begin
        if (fb_next[7:2] != 6'h22) begin
          case (fb_next[5:3])
            SEL_ADD: res_op = OP_ADD;
            SEL_SUB: res_op = OP_SUB;
            SEL_CMP: res_op = OP_CMP;
            default: res_ok = 1'b0;
          endcase
        end
        res_w   = fb_next[0];
        res_d   = fb_next[1];
        res_reg = modrm_next[5:3];
      end
      F_IMMRM: begin
        if (!((fb_next == OPC_MOV_IMM_B) || (fb_next == OPC_MOV_IMM_W))) begin
          case (modrm_next[5:3])
            SEL_ADD: res_op = OP_ADD;
            SEL_SUB: res_op = OP_SUB;
            SEL_CMP: res_op = OP_CMP;
            default: res_ok = 1'b0;
          endcase
        end
        res_w = fb_next[0];
      end
      F_IMMREG: begin
        res_w   = fb_next[3];
        res_reg = fb_next[2:0];
      end
      F_ACCADDR: begin
        res_w = fb_next[0];
        res_d = ~fb_next[1];
      end
      F_SEG: begin
        res_w   = 1'b1;
        res_d   = (fb_next == OPC_SEG_FROM_RM);
        res_reg = modrm_next[5:3];
      end
      F_IMMACC: begin
        case (fb_next[5:3])
          SEL_ADD: res_op = OP_ADD;
          SEL_SUB: res_op = OP_SUB;
          SEL_CMP: res_op = OP_CMP;
          default: res_ok = 1'b0;
        endcase
        res_w = fb_next[0];
      end
      default: res_op = OP_JUMP;
    endcase
    res_mod = has_modrm(res_form) ? modrm_next[7:6] : 2'd0;
    res_rm  = has_modrm(res_form) ? modrm_next[2:0] : 3'd0;
  end

  // state, input register and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full         <= 1'b0;
      phase           <= PH_IDLE;
      held_first_byte <= 8'h00;
      held_modrm      <= 8'h00;
      disp_accum      <= 16'h0000;
      data_accum      <= 16'h0000;
      bytes_taken     <= 3'd0;
      result_valid    <= 1'b0;
    end else begin
      if (code_valid && !code_stall) begin
        in_full <= 1'b1;
        in_byte <= code_byte;
      end else if (advance) begin
        in_full <= 1'b0;
      end

      if (advance) begin
        phase           <= phase_next;
        held_first_byte <= fb_next;
        held_modrm      <= modrm_next;
        disp_accum      <= disp_next;
        data_accum      <= data_next;
        bytes_taken     <= bytes_next;
      end

      if (advance && emit) begin
        result_valid <= 1'b1;
        opcode_byte  <= fb_next;
        length       <= bytes_next;
        if (first_bad) begin
          op_kind        <= OP_MOV;
          form           <= F_RMREG;
          word_flag      <= 1'b0;
          direction_flag <= 1'b0;
          mode_field     <= 2'd0;
          reg_field      <= 3'd0;
          rm_field       <= 3'd0;
          displacement   <= 16'sd0;
          data_value     <= 16'h0000;
          bad_opcode     <= 1'b1;
        end else begin
          op_kind        <= res_ok ? res_op : OP_MOV;
          form           <= res_form;
          word_flag      <= res_w;
          direction_flag <= res_d;
          mode_field     <= res_mod;
          reg_field      <= res_reg;
          rm_field       <= res_rm;
          displacement   <= $signed(disp_next);
          data_value     <= data_next;
          bad_opcode     <= !res_ok;
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // a result word always reports a length between one and six bytes
  a_length_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (length != 3'd0) && (length <= 3'd6))
    else $error("result length out of range");

  // an unknown first byte reports only the opcode
  a_bad_first: assert property (@(posedge clk) disable iff (rst)
    (result_valid && bad_opcode && (length == 3'd1)) |->
      (op_kind == OP_MOV) && (form == F_RMREG) && (displacement == 16'sd0) &&
      (data_value == 16'h0000))
    else $error("bad first byte result carries decoded fields");

  // jumps are always two bytes with the jump operation
  a_jump_shape: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (form == F_JUMP)) |-> (op_kind == OP_JUMP) && (length == 3'd2))
    else $error("jump result malformed");

  // a supported first byte never completes on its own
  a_first_waits: assert property (@(posedge clk) disable iff (rst)
    (advance && (phase == PH_IDLE) && classify_ok(in_byte)) |=> (phase != PH_IDLE))
    else $error("decoder returned to idle after a supported first byte");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_x86_16bit_instruction_decoder.sv -----
// ----------------------------------------------------------------------------
// tb_x86_16bit_instruction_decoder
// Self-checking bench for the byte-serial 8086 subset decoder. A queue of code
// bytes feeds a clocked driver that idles at random. A clocked monitor stalls
// at random and compares every result word with a software decode of the
// accepted byte stream. The stream opens with directed instructions, then
// mostly well-formed random instructions mixed with noise and cut-off ones.
// ----------------------------------------------------------------------------
module tb_x86_16bit_instruction_decoder
  import x86d_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // decoder states
  typedef enum logic [2:0] {
    ST_IDLE, ST_MODRM, ST_DISP_LO, ST_DISP_HI, ST_DATA_LO, ST_DATA_HI
  } dec_state_t;

  // one decoded instruction as seen on the result channel
  typedef struct packed {
    logic [2:0]  op;
    form_t       frm;
    logic [7:0]  opc;
    logic        w;
    logic        d;
    logic [1:0]  mode;
    logic [2:0]  reg_f;
    logic [2:0]  rm;
    logic [15:0] disp;
    logic [15:0] data;
    logic [2:0]  len;
    logic        bad;
  } dec_word_t;

  typedef struct {
    logic [7:0] b;
    bit         hold;
  } code_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic code_valid = 1'b0;
  logic code_stall;
  logic [7:0] code_byte = 8'h00;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [2:0] op_kind;
  logic [2:0] form;
  logic [7:0] opcode_byte;
  logic word_flag;
  logic direction_flag;
  logic [1:0] mode_field;
  logic [2:0] reg_field;
  logic [2:0] rm_field;
  logic signed [15:0] displacement;
  logic [15:0] data_value;
  logic [2:0] length;
  logic bad_opcode;

  code_item_t stream_bytes[$];
  dec_word_t decoded_words[$];
  int stream_total = 0;
  int bytes_taken_n = 0;
  int words_seen = 0;
  int holdoff_left = 0;
  int errors = 0;
  bit hold_first = 0;

  // decode state of the software model
  dec_state_t st = ST_IDLE;
  logic [7:0] first_b = 8'h00;
  logic [7:0] modrm_b = 8'h00;
  logic [15:0] disp_acc = 16'h0000;
  logic [15:0] data_acc = 16'h0000;
  logic [2:0] taken = 3'd0;

  x86_16bit_instruction_decoder uut (
    .clk(clk), .rst(rst),
    .code_valid(code_valid), .code_stall(code_stall), .code_byte(code_byte),
    .result_valid(result_valid), .result_stall(result_stall),
    .op_kind(op_kind), .form(form), .opcode_byte(opcode_byte),
    .word_flag(word_flag), .direction_flag(direction_flag),
    .mode_field(mode_field), .reg_field(reg_field), .rm_field(rm_field),
    .displacement(displacement), .data_value(data_value),
    .length(length), .bad_opcode(bad_opcode)
  );

  always #5 clk = ~clk;

  // form of a first byte, 0 when outside the subset
  function automatic bit sort_opcode(input logic [7:0] fb, output form_t f);
    f = F_RMREG;
    if (fb[7:2] == 6'h22) f = F_RMREG;
    else if (fb[7:1] == 7'h63) f = F_IMMRM;
    else if (fb[7:4] == 4'hB) f = F_IMMREG;
    else if (fb[7:2] == 6'h28) f = F_ACCADDR;
    else if (fb == OPC_SEG_TO_RM || fb == OPC_SEG_FROM_RM) f = F_SEG;
    else if (fb[7:2] == 6'h20) f = F_IMMRM;
    else if (fb[7:2] inside {6'h00, 6'h0A, 6'h0E}) f = F_RMREG;
    else if (fb[7:1] inside {7'h02, 7'h16, 7'h1E}) f = F_IMMACC;
    else if (fb[7:4] == 4'h7 || fb[7:2] == 6'h38) f = F_JUMP;
    else return 1'b0;
    return 1'b1;
  endfunction

  function automatic bit uses_modrm(input form_t f);
    return f == F_RMREG || f == F_IMMRM || f == F_SEG;
  endfunction

  function automatic int disp_bytes(input logic [7:0] m);
    case (m[7:6])
      2'd0: return (m[2:0] == RM_DIRECT) ? 2 : 0;
      2'd1: return 1;
      2'd2: return 2;
      default: return 0;
    endcase
  endfunction

  function automatic int imm_bytes(input logic [7:0] fb, input form_t f);
    case (f)
      F_IMMRM: begin
        if (fb == OPC_MOV_IMM_B || fb == OPC_MOV_IMM_W) return fb[0] ? 2 : 1;
        return (fb[1:0] == 2'b01) ? 2 : 1;
      end
      F_IMMREG:  return fb[3] ? 2 : 1;
      F_ACCADDR: return 2;
      F_IMMACC:  return fb[0] ? 2 : 1;
      F_JUMP:    return 1;
      default:   return 0;
    endcase
  endfunction

  // add, sub or cmp from a selector, mov and 0 when unsupported
  function automatic bit arith_op(input logic [2:0] sel, output logic [2:0] op);
    op = OP_MOV;
    case (sel)
      SEL_ADD: op = OP_ADD;
      SEL_SUB: op = OP_SUB;
      SEL_CMP: op = OP_CMP;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // result word of the held instruction, back to idle
  function automatic dec_word_t build_word();
    dec_word_t w;
    form_t f;
    bit ok;
    w = '0;
    ok = 1'b1;
    void'(sort_opcode(first_b, f));
    w.frm = f;
    w.opc = first_b;
    case (f)
      F_RMREG: begin
        if (first_b[7:2] != 6'h22) ok = arith_op(first_b[5:3], w.op);
        w.w = first_b[0];
        w.d = first_b[1];
        w.reg_f = modrm_b[5:3];
      end
      F_IMMRM: begin
        if (first_b != OPC_MOV_IMM_B && first_b != OPC_MOV_IMM_W)
          ok = arith_op(modrm_b[5:3], w.op);
        w.w = first_b[0];
      end
      F_IMMREG: begin
        w.w = first_b[3];
        w.reg_f = first_b[2:0];
      end
      F_ACCADDR: begin
        w.w = first_b[0];
        w.d = ~first_b[1];
      end
      F_SEG: begin
        w.w = 1'b1;
        w.d = (first_b == OPC_SEG_FROM_RM);
        w.reg_f = modrm_b[5:3];
      end
      F_IMMACC: begin
        ok = arith_op(first_b[5:3], w.op);
        w.w = first_b[0];
      end
      default: w.op = OP_JUMP;
    endcase
    if (uses_modrm(f)) begin
      w.mode = modrm_b[7:6];
      w.rm = modrm_b[2:0];
    end
    w.disp = disp_acc;
    w.data = data_acc;
    w.len = taken;
    w.bad = ~ok;
    st = ST_IDLE;
    return w;
  endfunction

  // after modrm or displacement: go on to data or finish
  function automatic bit finish_or_data(output dec_word_t w);
    form_t f;
    w = '0;
    void'(sort_opcode(first_b, f));
    if (imm_bytes(first_b, f) > 0) begin
      st = ST_DATA_LO;
      return 1'b0;
    end
    w = build_word();
    return 1'b1;
  endfunction

  // advance the software decoder by one byte, 1 when a word comes out
  function automatic bit decode_byte(input logic [7:0] b, output dec_word_t w);
    form_t f;
    w = '0;
    case (st)
      ST_MODRM: begin
        modrm_b = b;
        taken = taken + 3'd1;
        if (disp_bytes(b) > 0) begin
          st = ST_DISP_LO;
          return 1'b0;
        end
        return finish_or_data(w);
      end
      ST_DISP_LO: begin
        taken = taken + 3'd1;
        disp_acc = {8'h00, b};
        if (disp_bytes(modrm_b) == 2) begin
          st = ST_DISP_HI;
          return 1'b0;
        end
        if (b[7]) disp_acc = disp_acc | SIGN_FILL;
        return finish_or_data(w);
      end
      ST_DISP_HI: begin
        taken = taken + 3'd1;
        disp_acc[15:8] = b;
        return finish_or_data(w);
      end
      ST_DATA_LO: begin
        taken = taken + 3'd1;
        data_acc = {8'h00, b};
        void'(sort_opcode(first_b, f));
        if (imm_bytes(first_b, f) == 2) begin
          st = ST_DATA_HI;
          return 1'b0;
        end
        if (first_b == OPC_GRP_SX && b[7]) data_acc = data_acc | SIGN_FILL;
        w = build_word();
        return 1'b1;
      end
      ST_DATA_HI: begin
        taken = taken + 3'd1;
        data_acc[15:8] = b;
        w = build_word();
        return 1'b1;
      end
      default: begin
        // first byte of a new instruction
        first_b = b;
        modrm_b = 8'h00;
        disp_acc = 16'h0000;
        data_acc = 16'h0000;
        taken = 3'd1;
        if (!sort_opcode(b, f)) begin
          w.frm = F_RMREG;
          w.opc = b;
          w.len = 3'd1;
          w.bad = 1'b1;
          st = ST_IDLE;
          return 1'b1;
        end
        st = uses_modrm(f) ? ST_MODRM : ST_DATA_LO;
        return 1'b0;
      end
    endcase
  endfunction

  // queue one instruction, keeping at most keep of its bytes
  task automatic put_insn(input logic [7:0] fb, input logic [7:0] modrm,
                          input logic [15:0] disp, input logic [15:0] dat,
                          input int keep);
    logic [7:0] seq[$];
    form_t f;
    int nd;
    int nv;
    code_item_t it;
    seq.push_back(fb);
    if (sort_opcode(fb, f)) begin
      if (uses_modrm(f)) begin
        seq.push_back(modrm);
        nd = disp_bytes(modrm);
        if (nd > 0) seq.push_back(disp[7:0]);
        if (nd > 1) seq.push_back(disp[15:8]);
      end
      nv = imm_bytes(fb, f);
      if (nv > 0) seq.push_back(dat[7:0]);
      if (nv > 1) seq.push_back(dat[15:8]);
    end
    for (int i = 0; i < seq.size() && i < keep; i++) begin
      it.b = seq[i];
      it.hold = hold_first && (i == 0);
      stream_bytes.push_back(it);
      stream_total++;
    end
    hold_first = 0;
  endtask

  function automatic void field_diff(input string name, input logic [15:0] e,
                                     input logic [15:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
    end
  endfunction

  // driver: present bytes, hold a stalled byte, feed the model on acceptance
  always @(posedge clk) begin : drive_proc
    dec_word_t nxt;
    bit calm;
    if (rst) begin
      code_valid <= 1'b0;
    end else begin
      if (code_valid && !code_stall) begin
        if (decode_byte(code_byte, nxt)) decoded_words.push_back(nxt);
        bytes_taken_n++;
      end
      if (!(code_valid && code_stall)) begin
        calm = (bytes_taken_n >= 700 && bytes_taken_n < 1000);
        if (stream_bytes.size() > 0 && (calm || $urandom_range(0, 99) >= 11) &&
            !(stream_bytes[0].hold && decoded_words.size() != 0)) begin
          code_valid <= 1'b1;
          code_byte <= stream_bytes[0].b;
          void'(stream_bytes.pop_front());
        end else begin
          code_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each taken word, stall at random and once for long
  always @(posedge clk) begin : watch_proc
    dec_word_t e;
    dec_word_t a;
    bit calm;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        a = {op_kind, form_t'(form), opcode_byte, word_flag, direction_flag,
             mode_field, reg_field, rm_field, displacement, data_value,
             length, bad_opcode};
        if (decoded_words.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word, expected none, actual %h", $time, a);
        end else begin
          e = decoded_words.pop_front();
          field_diff("op_kind", {13'b0, e.op}, {13'b0, a.op});
          field_diff("form", {13'b0, e.frm}, {13'b0, a.frm});
          field_diff("opcode_byte", {8'b0, e.opc}, {8'b0, a.opc});
          field_diff("word_flag", {15'b0, e.w}, {15'b0, a.w});
          field_diff("direction_flag", {15'b0, e.d}, {15'b0, a.d});
          field_diff("mode_field", {14'b0, e.mode}, {14'b0, a.mode});
          field_diff("reg_field", {13'b0, e.reg_f}, {13'b0, a.reg_f});
          field_diff("rm_field", {13'b0, e.rm}, {13'b0, a.rm});
          field_diff("displacement", e.disp, a.disp);
          field_diff("data_value", e.data, a.data);
          field_diff("length", {13'b0, e.len}, {13'b0, a.len});
          field_diff("bad_opcode", {15'b0, e.bad}, {15'b0, a.bad});
        end
        words_seen++;
        if (words_seen == 300) holdoff_left = 400;
      end
      calm = (words_seen >= 100 && words_seen < 250);
      if (holdoff_left > 0) begin
        result_stall <= 1'b1;
        holdoff_left--;
      end else begin
        result_stall <= !calm && ($urandom_range(0, 99) < 11);
      end
    end
  end

  // stimulus and end of run
  initial begin : stim_proc
    logic [7:0] fb;
    form_t f;
    int r;
    bit mid_pause;
    mid_pause = 0;

    // directed: each form and operation, edge bytes and special cases
    put_insn(8'h00, 8'hC0, 16'h0000, 16'h0000, 8);
    put_insn(8'h89, 8'h06, 16'h1234, 16'h0000, 8);   // direct address
    put_insn(8'h8B, 8'h47, 16'h0080, 16'h0000, 8);   // negative byte disp
    put_insn(8'h88, 8'h9F, 16'hFFFF, 16'h0000, 8);
    put_insn(OPC_MOV_IMM_B, 8'h00, 16'h0000, 16'h00FF, 8);
    put_insn(OPC_MOV_IMM_W, 8'h46, 16'h007F, 16'hABCD, 8);
    put_insn(8'hB0, 8'h00, 16'h0000, 16'h0000, 8);
    put_insn(8'hBF, 8'h00, 16'h0000, 16'hFFFF, 8);
    put_insn(8'hA1, 8'h00, 16'h0000, 16'h8000, 8);
    put_insn(8'hA2, 8'h00, 16'h0000, 16'h0001, 8);
    put_insn(OPC_SEG_TO_RM, 8'h46, 16'h0090, 16'h0000, 8);   // segment, memory
    put_insn(OPC_SEG_FROM_RM, 8'hD8, 16'h0000, 16'h0000, 8);
    put_insn(8'h80, 8'hC1, 16'h0000, 16'h007F, 8);
    put_insn(8'h81, 8'h2E, 16'h5555, 16'hAAAA, 8);
    put_insn(OPC_GRP_SX, 8'hF8, 16'h0000, 16'h0080, 8);      // sign-extended imm
    put_insn(OPC_GRP_SX, 8'hC0, 16'h0000, 16'h007F, 8);
    put_insn(8'h82, 8'h08, 16'h0000, 16'h0033, 8);           // unsupported group op
    put_insn(8'h2B, 8'h50, 16'h0001, 16'h0000, 8);
    put_insn(8'h38, 8'hE1, 16'h0000, 16'h0000, 8);
    put_insn(8'h05, 8'h00, 16'h0000, 16'hFFFF, 8);
    put_insn(8'h2C, 8'h00, 16'h0000, 16'h0080, 8);
    put_insn(8'h3C, 8'h00, 16'h0000, 16'h0001, 8);
    put_insn(8'h70, 8'h00, 16'h0000, 16'h0080, 8);
    put_insn(8'h7F, 8'h00, 16'h0000, 16'h007F, 8);
    put_insn(8'hE0, 8'h00, 16'h0000, 16'h00FE, 8);
    put_insn(8'hE3, 8'h00, 16'h0000, 16'h0000, 8);
    put_insn(8'hFF, 8'h00, 16'h0000, 16'h0000, 8);           // unknown first byte
    put_insn(8'h0F, 8'h00, 16'h0000, 16'h0000, 8);

    // random: mostly whole instructions, some noise and cut-off ones
    hold_first = 1;
    while (stream_total < 1750) begin
      if (!mid_pause && stream_total >= 900) begin
        hold_first = 1;
        mid_pause = 1;
      end
      r = $urandom_range(0, 99);
      if (r < 85) begin
        do fb = 8'($urandom_range(0, 255)); while (!sort_opcode(fb, f));
        put_insn(fb, 8'($urandom_range(0, 255)), 16'($urandom), 16'($urandom), 8);
      end else if (r < 93) begin
        put_insn(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 16'($urandom), 16'($urandom), 1);
      end else begin
        do fb = 8'($urandom_range(0, 255)); while (!sort_opcode(fb, f));
        put_insn(fb, 8'($urandom_range(0, 255)), 16'($urandom), 16'($urandom),
                 $urandom_range(1, 3));
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken_n < stream_total) @(posedge clk);
    while (decoded_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

endmodule
